FILE: src/belr_pkg.sv
// Package for the bidi explicit level resolver.
// Holds the payload and stack entry types, the class codes and the
// controller/datapath command and status structs. No dependencies.
package belr_pkg;

  localparam int CLASS_W     = 5;
  localparam int LEVEL_W     = 7;
  localparam int SP_W        = 7;
  localparam int STACK_DEPTH = 128;
  localparam int VI_MAX      = 127;

  localparam logic [CLASS_W-1:0] C_L   = 5'd0;
  localparam logic [CLASS_W-1:0] C_LRE = 5'd1;
  localparam logic [CLASS_W-1:0] C_LRO = 5'd2;
  localparam logic [CLASS_W-1:0] C_R   = 5'd3;
  localparam logic [CLASS_W-1:0] C_RLE = 5'd5;
  localparam logic [CLASS_W-1:0] C_RLO = 5'd6;
  localparam logic [CLASS_W-1:0] C_PDF = 5'd7;
  localparam logic [CLASS_W-1:0] C_BN  = 5'd14;
  localparam logic [CLASS_W-1:0] C_B   = 5'd15;
  localparam logic [CLASS_W-1:0] C_LRI = 5'd19;
  localparam logic [CLASS_W-1:0] C_RLI = 5'd20;
  localparam logic [CLASS_W-1:0] C_FSI = 5'd21;
  localparam logic [CLASS_W-1:0] C_PDI = 5'd22;

  localparam logic [1:0] OV_NONE = 2'd0;
  localparam logic [1:0] OV_LTR  = 2'd1;
  localparam logic [1:0] OV_RTL  = 2'd2;

  typedef struct packed {
    logic [CLASS_W-1:0] bidi_class;
    logic               fsi_resolves_rtl;
  } belr_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] embedding_level;
    logic               level_assigned;
    logic [CLASS_W-1:0] resolved_class;
  } belr_out_t;

  typedef struct packed {
    logic               iso;
    logic [1:0]         ovr;
    logic [LEVEL_W-1:0] level;
  } belr_entry_t;

  typedef struct packed {
    logic take_item;
    logic cfg_write;
    logic pop_step;
    logic pop_finish;
  } belr_cmd_t;

  typedef struct packed {
    logic starts_pop;
    logic pop_done;
  } belr_status_t;

  function automatic logic [CLASS_W-1:0] apply_override(belr_entry_t e,
                                                        logic [CLASS_W-1:0] cls);
    logic [CLASS_W-1:0] r;
    r = cls;
    if (e.ovr == OV_LTR) begin
      r = C_L;
    end else if (e.ovr == OV_RTL) begin
      r = C_R;
    end
    return r;
  endfunction

endpackage

FILE: src/belr_ctrl.sv
// Controller for the bidi explicit level resolver.
// Runs the handshakes and sequences multi-entry stack pops; uses belr_pkg.
module belr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  belr_pkg::belr_status_t status,
  output belr_pkg::belr_cmd_t    cmd
);
  import belr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic state;
  logic state_next;
  logic result_valid_next;
  logic item_acc;

  assign cfg_ready  = (state == ST_IDLE);
  assign item_ready = (state == ST_IDLE) && !cfg_valid && (!result_valid || result_ready);
  assign item_acc   = item_valid && item_ready;

  always_comb begin
    cmd.take_item  = item_acc;
    cmd.cfg_write  = cfg_valid && cfg_ready;
    cmd.pop_step   = (state == ST_LOAD) && !status.pop_done;
    cmd.pop_finish = (state == ST_LOAD) && status.pop_done;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_acc && status.starts_pop) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.pop_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if ((item_acc && !status.starts_pop) || cmd.pop_finish) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: src/belr_datapath.sv
// Datapath for the bidi explicit level resolver: status stack memory,
// cached top entry, counters and the result register; uses belr_pkg.
module belr_datapath #(
  parameter int MAX_LEVEL    = 125,
  parameter int COUNTER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  belr_pkg::belr_cmd_t    cmd,
  output belr_pkg::belr_status_t status,
  input  belr_pkg::belr_in_t     item,
  input  logic                  cfg_data,
  output belr_pkg::belr_out_t    result
);
  import belr_pkg::*;

  belr_entry_t mem [STACK_DEPTH];
  belr_entry_t rdata;
  belr_entry_t top;
  belr_entry_t new_top;
  belr_entry_t para_entry;
  belr_entry_t push_entry;
  belr_out_t   item_res;

  logic                    para;
  logic [SP_W-1:0]         sp;
  logic [COUNTER_BITS-1:0] oi;
  logic [COUNTER_BITS-1:0] oe;
  logic [SP_W-1:0]         vi;
  logic                    popped_iso;
  logic                    pop_pdi;

  logic [CLASS_W-1:0]      cls;
  logic                    is_emb;
  logic                    is_iso;
  logic                    is_pdi;
  logic                    is_pdf;
  logic                    is_bn;
  logic                    is_b;
  logic                    odd;
  logic [LEVEL_W:0]        nl;
  logic                    can_push;
  logic                    push_we;
  logic                    pdi_pop;
  logic                    pdf_pop;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  assign cls    = item.bidi_class;
  assign is_emb = (cls == C_LRE) || (cls == C_RLE) || (cls == C_LRO) || (cls == C_RLO);
  assign is_iso = (cls == C_LRI) || (cls == C_RLI) || (cls == C_FSI);
  assign is_pdi = (cls == C_PDI);
  assign is_pdf = (cls == C_PDF);
  assign is_bn  = (cls == C_BN);
  assign is_b   = (cls == C_B);
  assign odd    = is_emb ? ((cls == C_RLE) || (cls == C_RLO))
                         : ((cls == C_RLI) || ((cls == C_FSI) && item.fsi_resolves_rtl));

  // Least odd or even level strictly above the top level.
  always_comb begin
    if (odd) begin
      nl = {1'b0, top.level} + (top.level[0] ? 8'd2 : 8'd1);
    end else begin
      nl = {1'b0, top.level} + (top.level[0] ? 8'd1 : 8'd2);
    end
  end

  assign can_push = (nl <= (LEVEL_W+1)'(MAX_LEVEL)) && (oi == '0) && (oe == '0) &&
                    (sp != SP_W'(STACK_DEPTH - 1));

  assign para_entry = '{iso: 1'b0, ovr: OV_NONE, level: {{(LEVEL_W-1){1'b0}}, para}};

  always_comb begin
    push_entry.level = nl[LEVEL_W-1:0];
    push_entry.iso   = is_iso;
    if (is_iso) begin
      push_entry.ovr = OV_NONE;
    end else if (cls == C_RLO) begin
      push_entry.ovr = OV_RTL;
    end else if (cls == C_LRO) begin
      push_entry.ovr = OV_LTR;
    end else begin
      push_entry.ovr = OV_NONE;
    end
  end

  assign push_we = cmd.take_item && (is_emb || is_iso) && can_push;
  assign pdi_pop = is_pdi && (oi == '0) && (vi != '0) && (sp != '0);
  assign pdf_pop = is_pdf && (oi == '0) && (oe == '0) && !top.iso && (sp != '0);

  // Entry zero always holds the paragraph entry, so it never comes from memory.
  assign new_top = (sp == '0) ? para_entry : rdata;

  assign status.starts_pop = pdi_pop || pdf_pop;
  assign status.pop_done   = popped_iso || (sp == '0);

  always_comb begin
    item_res.embedding_level = is_b ? {{(LEVEL_W-1){1'b0}}, para} : top.level;
    item_res.level_assigned  = !(is_emb || is_pdf || is_bn);
    if (is_emb || is_pdf || is_bn || is_b) begin
      item_res.resolved_class = cls;
    end else begin
      item_res.resolved_class = apply_override(top, cls);
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[sp + SP_W'(1)] <= push_entry;
    end
    rdata <= mem[sp - SP_W'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      para <= 1'b0;
      sp   <= '0;
      top  <= '{iso: 1'b0, ovr: OV_NONE, level: '0};
      oi   <= '0;
      oe   <= '0;
      vi   <= '0;
    end else if (cmd.cfg_write) begin
      para <= cfg_data;
      sp   <= '0;
      top  <= '{iso: 1'b0, ovr: OV_NONE, level: {{(LEVEL_W-1){1'b0}}, cfg_data}};
      oi   <= '0;
      oe   <= '0;
      vi   <= '0;
    end else if (cmd.take_item) begin
      if (is_emb) begin
        if (can_push) begin
          sp  <= sp + SP_W'(1);
          top <= push_entry;
        end else if ((oi == '0) && (oe != CNT_MAX)) begin
          oe <= oe + COUNTER_BITS'(1);
        end
      end else if (is_iso) begin
        if (can_push) begin
          if (vi != SP_W'(VI_MAX)) begin
            vi <= vi + SP_W'(1);
          end
          sp  <= sp + SP_W'(1);
          top <= push_entry;
        end else if (oi != CNT_MAX) begin
          oi <= oi + COUNTER_BITS'(1);
        end
      end else if (is_pdi) begin
        if (oi != '0) begin
          oi <= oi - COUNTER_BITS'(1);
        end else if (vi != '0) begin
          oe <= '0;
          vi <= vi - SP_W'(1);
          if (sp != '0) begin
            sp <= sp - SP_W'(1);
          end
        end
      end else if (is_pdf) begin
        if (oi != '0) begin
          oi <= oi;
        end else if (oe != '0) begin
          oe <= oe - COUNTER_BITS'(1);
        end else if (pdf_pop) begin
          sp <= sp - SP_W'(1);
        end
      end else if (is_b) begin
        sp  <= '0;
        top <= para_entry;
        oi  <= '0;
        oe  <= '0;
        vi  <= '0;
      end
    end else if (cmd.pop_step) begin
      sp  <= sp - SP_W'(1);
      top <= new_top;
    end else if (cmd.pop_finish) begin
      top <= new_top;
    end
  end

  // Pop bookkeeping and the result register carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      popped_iso <= pdf_pop ? 1'b1 : top.iso;
      pop_pdi    <= pdi_pop;
      if (!pdi_pop) begin
        result <= item_res;
      end
    end else if (cmd.pop_step) begin
      popped_iso <= new_top.iso;
    end else if (cmd.pop_finish && pop_pdi) begin
      result.embedding_level <= new_top.level;
      result.level_assigned  <= 1'b1;
      result.resolved_class  <= apply_override(new_top, C_PDI);
    end
  end

endmodule

FILE: src/bidi_explicit_level_resolver.sv
// Top level of the bidi explicit level resolver (rules X1 to X8).
// Joins belr_ctrl and belr_datapath; uses belr_pkg for types.
//
// Usage: one bidi class per character enters on the item channel
// (valid/ready); exactly one result per character leaves on the result
// channel, in order. The FSI direction is supplied with the item.
// cfg_valid/cfg_ready/cfg_data write the paragraph level and start a new
// paragraph; writes are taken only between items.
// Most characters give a valid result in the cycle after acceptance.
// A PDF that pops and a PDI that closes an isolate go through the load
// state, which pops stack entries one by one; each pop reads the stack
// memory's registered port once. No item is taken until the pops end.
// Reset clears the stack to the paragraph entry (level 0) and all counters;
// no clearing pass is needed since entries are written before being read.
// When the receiver stalls, the result register holds the result and the
// block takes the next item only in a cycle where that result leaves.
module bidi_explicit_level_resolver #(
  parameter int MAX_LEVEL    = 125,
  parameter int COUNTER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  belr_pkg::belr_in_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output belr_pkg::belr_out_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import belr_pkg::*;

  belr_cmd_t    cmd;
  belr_status_t status;

  belr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  belr_datapath #(
    .MAX_LEVEL    (MAX_LEVEL),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .cfg_data (cfg_data),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  // A new item is taken only when the result register is free or draining.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (!result_valid || result_ready))
    else $error("item taken while result register blocked");

  // Configuration and items never complete in the same cycle.
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !item_ready)
    else $error("item ready during configuration write");

  // Characters other than PDI and PDF give their result in the next cycle.
  a_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.bidi_class != C_PDI) &&
     (item.bidi_class != C_PDF)) |=> result_valid)
    else $error("single-cycle character produced no result");

  // While a pop sequence runs, no new transaction is taken.
  a_pop_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_step || cmd.pop_finish) |-> (!item_ready && !cfg_ready))
    else $error("channel open during stack pop");
`endif

endmodule

FILE: test/belr_level_checker.sv
// Checker for the bidi explicit level resolver: follows the item, result and
// paragraph level channels, predicts each character's result and compares.
// Depends on belr_pkg for the payload types and class codes.
module belr_level_checker #(
  parameter int MAX_LEVEL    = 125,
  parameter int COUNTER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  belr_pkg::belr_in_t  item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  belr_pkg::belr_out_t result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import belr_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_SAT = '1;

  // Shadow copy of the directional status stack and its counters.
  belr_entry_t             dss [STACK_DEPTH];
  logic [SP_W-1:0]         dss_top;
  logic [COUNTER_BITS-1:0] ovf_iso;
  logic [COUNTER_BITS-1:0] ovf_emb;
  logic [6:0]              iso_count;
  logic                    para_lvl;

  belr_out_t pending_levels [$];

  function automatic void start_text();
    for (int i = 0; i < STACK_DEPTH; i++) begin
      dss[i] = '0;
    end
    dss[0].level = LEVEL_W'(para_lvl);
    dss[0].ovr   = OV_NONE;
    dss[0].iso   = 1'b0;
    dss_top   = '0;
    ovf_iso   = '0;
    ovf_emb   = '0;
    iso_count = '0;
  endfunction

  function automatic logic [CLASS_W-1:0] override_class(logic [CLASS_W-1:0] cls);
    logic [CLASS_W-1:0] r;
    r = cls;
    if (dss[dss_top].ovr == OV_LTR) begin
      r = C_L;
    end else if (dss[dss_top].ovr == OV_RTL) begin
      r = C_R;
    end
    return r;
  endfunction

  // Least greater odd or even level above the current top.
  function automatic int raised_level(logic odd);
    int lv;
    lv = int'(dss[dss_top].level);
    if (odd) begin
      return (lv % 2 == 1) ? lv + 2 : lv + 1;
    end
    return (lv % 2 == 1) ? lv + 1 : lv + 2;
  endfunction

  function automatic logic push_allowed(int nl);
    return nl <= MAX_LEVEL && ovf_iso == 0 && ovf_emb == 0 &&
           int'(dss_top) < STACK_DEPTH - 1;
  endfunction

  function automatic void push_entry(int nl, logic [1:0] ov, logic iso);
    dss_top = dss_top + SP_W'(1);
    dss[dss_top].level = LEVEL_W'(nl);
    dss[dss_top].ovr   = ov;
    dss[dss_top].iso   = iso;
  endfunction

  function automatic belr_out_t resolve_char(belr_in_t it);
    belr_out_t          r;
    int                 nl;
    logic               odd;
    logic [1:0]         ov;
    logic [CLASS_W-1:0] cls;
    cls = it.bidi_class;
    r.embedding_level = dss[dss_top].level;
    r.level_assigned  = 1'b1;
    r.resolved_class  = cls;
    case (cls)
      C_LRE, C_RLE, C_LRO, C_RLO: begin
        odd = (cls == C_RLE) || (cls == C_RLO);
        ov  = (cls == C_RLO) ? OV_RTL : ((cls == C_LRO) ? OV_LTR : OV_NONE);
        nl  = raised_level(odd);
        r.level_assigned = 1'b0;
        if (push_allowed(nl)) begin
          push_entry(nl, ov, 1'b0);
        end else if (ovf_iso == 0 && ovf_emb != CNT_SAT) begin
          ovf_emb = ovf_emb + COUNTER_BITS'(1);
        end
      end
      C_LRI, C_RLI, C_FSI: begin
        odd = (cls == C_RLI) || (cls == C_FSI && it.fsi_resolves_rtl);
        nl  = raised_level(odd);
        r.resolved_class = override_class(cls);
        if (push_allowed(nl)) begin
          if (iso_count < VI_MAX) begin
            iso_count = iso_count + 7'd1;
          end
          push_entry(nl, OV_NONE, 1'b1);
        end else if (ovf_iso != CNT_SAT) begin
          ovf_iso = ovf_iso + COUNTER_BITS'(1);
        end
      end
      C_PDI: begin
        if (ovf_iso != 0) begin
          ovf_iso = ovf_iso - COUNTER_BITS'(1);
        end else if (iso_count != 0) begin
          // Close the innermost valid isolate, dropping embeddings above it.
          ovf_emb = '0;
          while (dss_top != 0 && !dss[dss_top].iso) begin
            dss_top = dss_top - SP_W'(1);
          end
          if (dss_top != 0) begin
            dss_top = dss_top - SP_W'(1);
          end
          iso_count = iso_count - 7'd1;
        end
        r.embedding_level = dss[dss_top].level;
        r.resolved_class  = override_class(cls);
      end
      C_PDF: begin
        r.level_assigned = 1'b0;
        if (ovf_iso != 0) begin
          // An overflowed isolate is still open, so the PDF does nothing.
        end else if (ovf_emb != 0) begin
          ovf_emb = ovf_emb - COUNTER_BITS'(1);
        end else if (!dss[dss_top].iso && dss_top != 0) begin
          dss_top = dss_top - SP_W'(1);
        end
      end
      C_BN: begin
        r.level_assigned = 1'b0;
      end
      C_B: begin
        r.embedding_level = LEVEL_W'(para_lvl);
        start_text();
      end
      default: begin
        r.resolved_class = override_class(cls);
      end
    endcase
    return r;
  endfunction

  int fails;

  always @(posedge clk) begin : watch
    belr_out_t want;
    if (rst) begin
      para_lvl = 1'b0;
      start_text();
      pending_levels.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (pending_levels.size() == 0) begin
          $error("result transaction with no character outstanding: %p", result);
          fails++;
        end else begin
          want = pending_levels.pop_front();
          if (result.embedding_level !== want.embedding_level) begin
            $error("embedding_level: expected %0d, actual %0d",
                   want.embedding_level, result.embedding_level);
            fails++;
          end
          if (result.level_assigned !== want.level_assigned) begin
            $error("level_assigned: expected %0d, actual %0d",
                   want.level_assigned, result.level_assigned);
            fails++;
          end
          if (result.resolved_class !== want.resolved_class) begin
            $error("resolved_class: expected %0d, actual %0d",
                   want.resolved_class, result.resolved_class);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        para_lvl = cfg_data;
        start_text();
      end
      if (item_valid && item_ready) begin
        pending_levels.push_back(resolve_char(item));
      end
    end
    pending    = pending_levels.size();
    fail_count = fails;
  end

endmodule

FILE: test/tb_bidi_explicit_level_resolver.sv
// Top of the bidi explicit level resolver testbench: clock, reset, character
// stimulus, paragraph level writes, result back-pressure and the verdict.
// Depends on belr_pkg, the block itself and belr_level_checker.
module tb_bidi_explicit_level_resolver;
  timeunit 1ns;
  timeprecision 1ps;

  import belr_pkg::*;

  localparam int MAX_LEVEL      = 125;
  localparam int COUNTER_BITS   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int CALM_AT_ITEM   = 830;
  localparam int DRAIN_CYCLES   = 150;

  // Class codes that the package leaves unnamed.
  localparam logic [CLASS_W-1:0] CL_AL   = 5'd4;
  localparam logic [CLASS_W-1:0] CL_EN   = 5'd8;
  localparam logic [CLASS_W-1:0] CL_ES   = 5'd9;
  localparam logic [CLASS_W-1:0] CL_ET   = 5'd10;
  localparam logic [CLASS_W-1:0] CL_AN   = 5'd11;
  localparam logic [CLASS_W-1:0] CL_CS   = 5'd12;
  localparam logic [CLASS_W-1:0] CL_NSM  = 5'd13;
  localparam logic [CLASS_W-1:0] CL_S    = 5'd16;
  localparam logic [CLASS_W-1:0] CL_WS   = 5'd17;
  localparam logic [CLASS_W-1:0] CL_ON   = 5'd18;
  localparam logic [CLASS_W-1:0] CL_LAST = 5'd31;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  belr_in_t  item;
  logic      result_valid;
  logic      result_ready;
  belr_out_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  int        fail_count;
  int        pending;

  int        items_sent;
  logic      calm;
  int        idle_cycles;

  bidi_explicit_level_resolver #(
    .MAX_LEVEL(MAX_LEVEL),
    .COUNTER_BITS(COUNTER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  belr_level_checker #(
    .MAX_LEVEL(MAX_LEVEL),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off so the block backs
  // up into its input, and no stalls near the end.
  initial begin : receiver
    int  hold;
    int  run;
    logic long_done;
    hold         = 0;
    run          = 0;
    long_done    = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && items_sent >= HOLD_AT_ITEM) begin
        long_done = 1'b1;
        hold      = LONG_HOLD;
      end
      if (hold > 0) begin
        result_ready <= 1'b0;
        hold--;
      end else if (run > 0 || calm) begin
        result_ready <= 1'b1;
        if (run > 0) begin
          run--;
        end
      end else if ($urandom_range(0, 2) == 0) begin
        result_ready <= 1'b0;
        hold = $urandom_range(1, 12) - 1;
      end else begin
        result_ready <= 1'b1;
        run = $urandom_range(0, 20);
      end
    end
  end

  function automatic logic [CLASS_W-1:0] ordinary_class();
    case ($urandom_range(0, 12))
      0:       return C_L;
      1:       return C_R;
      2:       return CL_AL;
      3:       return CL_EN;
      4:       return CL_ES;
      5:       return CL_ET;
      6:       return CL_AN;
      7:       return CL_CS;
      8:       return CL_NSM;
      9:       return CL_S;
      10:      return CL_WS;
      11:      return CL_ON;
      default: return CLASS_W'($urandom_range(int'(C_PDI) + 1, int'(CL_LAST)));
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] embed_class();
    case ($urandom_range(0, 3))
      0:       return C_LRE;
      1:       return C_RLE;
      2:       return C_LRO;
      default: return C_RLO;
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] isolate_class();
    case ($urandom_range(0, 2))
      0:       return C_LRI;
      1:       return C_RLI;
      default: return C_FSI;
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] text_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return ordinary_class();
    end else if (r < 50) begin
      return embed_class();
    end else if (r < 62) begin
      return C_PDF;
    end else if (r < 72) begin
      return isolate_class();
    end else if (r < 82) begin
      return C_PDI;
    end else if (r < 85) begin
      return C_B;
    end else if (r < 89) begin
      return C_BN;
    end
    return CLASS_W'($urandom_range(0, int'(CL_LAST)));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(logic [CLASS_W-1:0] cls, logic fsi);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    item.bidi_class       <= cls;
    item.fsi_resolves_rtl <= fsi;
    item_valid            <= 1'b1;
    do begin
      @(posedge clk);
    end while (!item_ready);
    items_sent++;
    if (items_sent >= CALM_AT_ITEM) begin
      calm = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic send_text(int n);
    repeat (n) begin
      send_char(text_class(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Embeddings nested past the maximum level inside one isolate, then the
  // overflow counters unwound and a PDI that pops the whole chain.
  task automatic deep_embeddings();
    send_char(isolate_class(), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(125, 132)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_char(ordinary_class(), 1'($urandom_range(0, 1)));
      end
      send_char(embed_class(), 1'($urandom_range(0, 1)));
    end
    send_char(isolate_class(), 1'($urandom_range(0, 1)));
    send_char(ordinary_class(), 1'($urandom_range(0, 1)));
    send_char(C_PDI, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(2, 5)) begin
      send_char(C_PDF, 1'($urandom_range(0, 1)));
    end
    send_char(ordinary_class(), 1'($urandom_range(0, 1)));
    send_char(C_PDI, 1'($urandom_range(0, 1)));
    send_char(ordinary_class(), 1'($urandom_range(0, 1)));
  endtask

  // Isolates nested past the maximum level, overflow isolates on top, then
  // a few closings and a paragraph separator.
  task automatic deep_isolates();
    repeat ($urandom_range(125, 130)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_char(ordinary_class(), 1'($urandom_range(0, 1)));
      end
      send_char(isolate_class(), 1'($urandom_range(0, 1)));
    end
    send_char(embed_class(), 1'($urandom_range(0, 1)));
    send_char(C_PDF, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(3, 10)) begin
      send_char(C_PDI, 1'($urandom_range(0, 1)));
      send_char(ordinary_class(), 1'($urandom_range(0, 1)));
    end
    send_char(C_B, 1'($urandom_range(0, 1)));
  endtask

  // Lets the block drain before the paragraph level is rewritten.
  task automatic drain();
    item_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_paragraph_level(logic lvl);
    cfg_data  <= lvl;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    items_sent  = 0;
    calm        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text at the reset paragraph level: overrides, isolates of
    // both FSI directions, a PDF at an isolate entry, a stray PDI, codes above
    // PDI and a paragraph separator.
    send_char(C_L, 1'b0);
    send_char(C_RLE, 1'b1);
    send_char(CL_AL, 1'b0);
    send_char(C_LRO, 1'b0);
    send_char(C_R, 1'b1);
    send_char(C_RLI, 1'b0);
    send_char(C_BN, 1'b1);
    send_char(C_FSI, 1'b1);
    send_char(C_FSI, 1'b0);
    send_char(C_PDF, 1'b0);
    send_char(C_PDI, 1'b0);
    send_char(C_PDI, 1'b1);
    send_char(C_PDI, 1'b0);
    send_char(CL_ON, 1'b0);
    send_char(C_RLO, 1'b0);
    send_char(CL_WS, 1'b1);
    send_char(C_PDF, 1'b0);
    send_char(C_PDF, 1'b1);
    send_char(C_PDF, 1'b0);
    send_char(C_PDI, 1'b0);
    send_char(CL_LAST, 1'b1);
    send_char(C_B, 1'b1);
    send_char(C_LRI, 1'b0);
    send_char(CL_S, 1'b0);
    send_char(C_PDI + CLASS_W'(1), 1'b0);
    drain();

    write_paragraph_level(1'b1);
    send_text(200);
    deep_embeddings();
    drain();
    write_paragraph_level(1'b0);
    send_text(150);
    deep_isolates();
    drain();
    write_paragraph_level(1'b1);
    send_text(150);
    drain();
    write_paragraph_level(1'b0);
    send_text(140);
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
